/* rtl/ist_pkg.sv */
// shared types and constants for the integer set table
`default_nettype none

package ist_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int VALUE_BITS_DEF = 32;
	localparam int DATA_BITS      = 32;
	localparam int COUNT_BITS     = 5;

	typedef enum logic [1:0] {
		KIND_ADD     = 2'd0,
		KIND_REMOVE  = 2'd1,
		KIND_MEMBER  = 2'd2,
		KIND_EXTRACT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                        kind;
		logic signed [DATA_BITS-1:0]  value;
	} req_item_t;

	typedef struct packed {
		status_t                      status;
		logic signed [DATA_BITS-1:0]  extracted_value;
		logic [COUNT_BITS-1:0]        count;
	} rsp_item_t;

	// per-cycle commands broadcast along the cell row
	typedef struct packed {
		logic append;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/ist_cell.sv */
// one entry cell of the set table row: compare, append, shift and readout
`default_nettype none

module ist_cell import ist_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int CNT_BITS   = 5,
	parameter int INDEX      = 0
) (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [CNT_BITS-1:0]   count,
	input  wire logic [VALUE_BITS-1:0] value,
	input  wire logic [VALUE_BITS-1:0] next_entry,
	input  wire logic                  hit_in,
	input  wire logic [VALUE_BITS-1:0] rdata_in,
	output logic      [VALUE_BITS-1:0] entry,
	output logic                       match,
	output logic                       hit_out,
	output logic      [VALUE_BITS-1:0] rdata_out
);

	localparam logic [CNT_BITS-1:0] MY_POS   = CNT_BITS'(INDEX);
	localparam logic [CNT_BITS-1:0] NEXT_POS = CNT_BITS'(INDEX + 1);

	logic [VALUE_BITS-1:0] entry_q;
	logic                  active;
	logic                  is_last;

	assign active    = MY_POS < count;
	assign is_last   = NEXT_POS == count;
	assign match     = active && (entry_q == value);
	// hit ripples down the row: set from the matching cell onwards
	assign hit_out   = hit_in | match;
	assign rdata_out = rdata_in | (is_last ? entry_q : '0);
	assign entry     = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.append && (MY_POS == count)) begin
			entry_q <= value;
		end else if (ctrl.shift && hit_out && (NEXT_POS < count)) begin
			entry_q <= next_entry;
		end
	end

endmodule

`default_nettype wire

/* rtl/integer_set_table_top.sv */
// top level of the integer set table: item register, cell row and result register
// an item waits in the item register until the result register is free or read,
// then its result is registered; the single item register, ahead of the
//   compare-and-shift ripple, takes no new item until its held item executes
// a new item is taken while the previous result still waits in the output register
// reset clears the entry count and the valid flags; entries are left undefined
`default_nettype none

module integer_set_table_top import ist_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_item_t      rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	rsp_item_t             rsp_q;

	logic                  exec;
	logic                  any_hit;
	logic                  full;
	cell_ctrl_t            ctrl;
	status_t               status_n;
	logic [CW-1:0]         count_n;
	logic [DATA_BITS-1:0]  extracted_n;

	logic [VALUE_BITS-1:0] entry_w [CAPACITY];
	logic [CAPACITY:0]     hit_w;
	logic [VALUE_BITS-1:0] rdata_w [CAPACITY+1];
	logic [CAPACITY-1:0]   match_w;

	assign req_ready = !valid_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign exec      = valid_s1 && (!rsp_valid_q || rsp_ready);

	assign hit_w[0]   = 1'b0;
	assign rdata_w[0] = '0;
	assign any_hit    = hit_w[CAPACITY];
	assign full       = count_q == FULL_COUNT;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] nxt;
		if (i == CAPACITY - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_body
			assign nxt = entry_w[i+1];
		end

		ist_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_BITS   (CW),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count_q),
			.value      (value_s1),
			.next_entry (nxt),
			.hit_in     (hit_w[i]),
			.rdata_in   (rdata_w[i]),
			.entry      (entry_w[i]),
			.match      (match_w[i]),
			.hit_out    (hit_w[i+1]),
			.rdata_out  (rdata_w[i+1])
		);
	end

	always_comb begin
		status_n    = ST_OK;
		count_n     = count_q;
		extracted_n = '0;
		ctrl        = '0;
		unique case (kind_s1)
			KIND_ADD: begin
				if (any_hit) begin
					status_n = ST_MISS;
				end else if (full) begin
					status_n = ST_FULL;
				end else begin
					count_n     = count_q + CW'(1);
					ctrl.append = exec;
				end
			end
			KIND_REMOVE: begin
				if (any_hit) begin
					count_n    = count_q - CW'(1);
					ctrl.shift = exec;
				end else begin
					status_n = ST_MISS;
				end
			end
			KIND_MEMBER: begin
				status_n = any_hit ? ST_OK : ST_MISS;
			end
			KIND_EXTRACT: begin
				if (count_q == '0) begin
					status_n = ST_MISS;
				end else begin
					count_n     = count_q - CW'(1);
					extracted_n = DATA_BITS'(signed'(rdata_w[CAPACITY]));
				end
			end
			default: begin
				status_n = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_valid && req_ready) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				count_q     <= count_n;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			kind_s1  <= req.kind;
			value_s1 <= VALUE_BITS'($unsigned(req.value));
		end
		if (exec) begin
			rsp_q.status          <= status_n;
			rsp_q.extracted_value <= extracted_n;
			rsp_q.count           <= COUNT_BITS'(count_n);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count beyond capacity");

	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(match_w))
		else $error("value stored in more than one cell");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (kind_s1 == KIND_ADD) && (status_n == ST_OK) |=>
		count_q == $past(count_q) + CW'(1))
		else $error("successful add did not grow the count");

	a_extract_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		exec && (kind_s1 == KIND_EXTRACT) && (status_n == ST_OK) |-> count_q != '0)
		else $error("extract succeeded on an empty table");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		exec |=> rsp_valid_q && !valid_s1)
		else $error("executed item left no result");

endmodule

`default_nettype wire

/* sim/integer_set_table_checker.sv */
// result checker for the integer set table: tracks the stored set and compares every result
`timescale 1ns / 1ps

module integer_set_table_checker import ist_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_ready,
	input  wire req_item_t req,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_ready,
	input  wire rsp_item_t rsp,
	output int             errors,
	output int             pending
);

	logic [DATA_BITS-1:0] set_words [CAPACITY_DEF];
	int                   held_count;
	rsp_item_t            awaited_q [$];

	// applies one item to the tracked set and returns the result it should give
	function automatic rsp_item_t apply_item(req_item_t item);
		rsp_item_t res;
		int        hit;
		int        i;
		res = '{status: ST_OK, extracted_value: '0, count: '0};
		hit = -1;
		for (i = 0; i < held_count; i++) begin
			if (hit < 0 && set_words[i] == item.value)
				hit = i;
		end
		case (item.kind)
			KIND_ADD: begin
				// duplicate wins over full
				if (hit >= 0)
					res.status = ST_MISS;
				else if (held_count >= CAPACITY_DEF)
					res.status = ST_FULL;
				else begin
					set_words[held_count] = item.value;
					held_count++;
				end
			end
			KIND_REMOVE: begin
				if (hit < 0)
					res.status = ST_MISS;
				else begin
					// close the gap so insertion order is kept
					for (i = hit; i + 1 < held_count; i++)
						set_words[i] = set_words[i + 1];
					held_count--;
				end
			end
			KIND_MEMBER: begin
				res.status = (hit >= 0) ? ST_OK : ST_MISS;
			end
			KIND_EXTRACT: begin
				if (held_count == 0)
					res.status = ST_MISS;
				else begin
					held_count--;
					res.extracted_value = set_words[held_count];
				end
			end
		endcase
		res.count = COUNT_BITS'(held_count);
		return res;
	endfunction

	initial begin
		errors     = 0;
		pending    = 0;
		held_count = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			held_count = 0;
			awaited_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: result with nothing awaited: status=%0d value=%0d count=%0d",
							$realtime, rsp.status, rsp.extracted_value, rsp.count);
				end else begin
					want = awaited_q.pop_front();
					if (rsp.status !== want.status ||
					    rsp.extracted_value !== want.extracted_value ||
					    rsp.count !== want.count) begin
						errors++;
						if (errors <= 10)
							$display({"%0t: mismatch: expected status=%0d value=%0d count=%0d,",
								" got status=%0d value=%0d count=%0d"}, $realtime,
								want.status, want.extracted_value, want.count,
								rsp.status, rsp.extracted_value, rsp.count);
					end
				end
			end
			if (req_valid && req_ready)
				awaited_q.push_back(apply_item(req));
		end
		pending = awaited_q.size();
	end

endmodule

/* sim/tb_integer_set_table_top.sv */
// testbench top for the integer set table: clock, reset, item traffic and verdict
`timescale 1ns / 1ps

module tb_integer_set_table_top import ist_pkg::*; ();

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_item_t req       = '{kind: KIND_ADD, value: '0};
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_item_t rsp;
	int        errors;
	int        pending;

	bit tx_steady = 1'b0;
	bit rx_hold   = 1'b0;

	integer_set_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	integer_set_table_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// offers one item and returns at the edge that accepts it, valid left high
	task automatic send_item(input kind_t k, input logic [DATA_BITS-1:0] v);
		int gap;
		gap = (tx_steady || rx_hold) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= '{kind: k, value: v};
		do @(posedge clk); while (!req_ready);
	endtask

	// result side: random stalls, steady stretches and two long hold-offs
	initial begin : result_side
		int  taken;
		int  stall;
		bit  steady;
		taken  = 0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			stall = steady ? 0 : $urandom_range(0, 18);
			if (taken == 400 || taken == 1300) begin
				stall   = 160;
				rx_hold = 1'b1;
			end
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rx_hold = 1'b0;
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	initial begin : item_side
		logic [DATA_BITS-1:0] pool [24];
		kind_t                k;
		logic [DATA_BITS-1:0] v;
		bit                   filling;
		int                   pick;
		int                   n;
		int                   j;
		int                   guard;
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7FFF_FFFF;
		pool[2] = 32'h0000_0000;
		pool[3] = 32'hFFFF_FFFF;
		filling = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store cases
		send_item(KIND_EXTRACT, 32'h1234_5678);
		send_item(KIND_REMOVE,  32'd5);
		send_item(KIND_MEMBER,  32'd5);
		// extremes, then a duplicate, a hit and a removal from the middle
		send_item(KIND_ADD,     32'h8000_0000);
		send_item(KIND_ADD,     32'h7FFF_FFFF);
		send_item(KIND_ADD,     32'hFFFF_FFFF);
		send_item(KIND_ADD,     32'h0000_0000);
		send_item(KIND_ADD,     32'h7FFF_FFFF);
		send_item(KIND_MEMBER,  32'hFFFF_FFFF);
		send_item(KIND_REMOVE,  32'h7FFF_FFFF);
		send_item(KIND_EXTRACT, 32'hFFFF_FFFF);
		// fill up, then an absent add and a duplicate add on the full store
		for (j = 0; j < 14; j++)
			send_item(KIND_ADD, 32'h5A5A_0001 ^ (j << 20) ^ (j << 3));
		send_item(KIND_ADD, 32'd12345);
		send_item(KIND_ADD, 32'h8000_0000);

		for (n = 0; n < 1900; n++) begin
			if (n % 150 == 0)
				for (j = 4; j < 24; j++)
					pool[j] = $urandom;
			if (n % 60 == 0)
				filling = $urandom_range(0, 1);
			if (n % 40 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			// a pool larger than the store keeps it cycling between empty and full
			if (filling) begin
				if (pick < 55)      k = KIND_ADD;
				else if (pick < 70) k = KIND_REMOVE;
				else if (pick < 85) k = KIND_MEMBER;
				else                k = KIND_EXTRACT;
			end else begin
				if (pick < 20)      k = KIND_ADD;
				else if (pick < 50) k = KIND_REMOVE;
				else if (pick < 70) k = KIND_MEMBER;
				else                k = KIND_EXTRACT;
			end
			v = ($urandom_range(0, 19) == 0) ? $urandom : pool[$urandom_range(0, 23)];
			send_item(k, v);
		end
		req_valid <= 1'b0;
		// let the checker book the last accepted item before draining
		@(posedge clk);

		guard = 0;
		while (pending != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb_integer_set_table_top: done, clean");
		else
			$display("tb_integer_set_table_top: done, errors");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("tb_integer_set_table_top: done, errors");
		$finish;
	end

endmodule
